/* design/koc_pkg.sv */
// Shared types and constants for the key occurrence counter.
package koc_pkg;

    localparam int unsigned KEY_FIELD_W   = 64;
    localparam int unsigned COUNT_W       = 32;
    localparam int unsigned DEPTH_DEF     = 64;
    localparam int unsigned KEY_BYTES_DEF = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

/* design/koc_if.sv */
// Valid/ready channel interfaces for key requests and count results.
interface koc_key_if;
    logic                            valid;
    logic                            ready;
    logic [koc_pkg::KEY_FIELD_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface koc_res_if;
    logic                        valid;
    logic                        ready;
    logic [koc_pkg::COUNT_W-1:0] count;
    logic                        is_new;
    logic                        table_full;

    modport source (output valid, output count, output is_new, output table_full, input ready);
    modport sink   (input valid, input count, input is_new, input table_full, output ready);
endinterface

/* design/koc_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module koc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/key_occurrence_counter_core.sv */
// Top level of the key occurrence counter: table search sequencer and result register.
//
// Each request carries one key; the low 8*KEY_BYTES bits are compared and stored, the rest
// are ignored. The block keeps a table of up to DEPTH (key, count) entries in a single RAM
// and walks it one entry per cycle through the RAM's read port, comparing each stored key
// with the request key. A hit bumps that entry's count (saturating at all ones) and returns
// the new count; a miss appends the key with count 1 and returns 1 with is_new set; a miss
// on a full table changes nothing and returns count 0 with table_full set. A miss on an
// empty table is decided in the cycle after it is taken; otherwise the search reads entries
// from entry 0 upward and is decided at the first hit or once every entry in use has been
// compared. A result that cannot leave the output register holds the search until it can.
// The request side is ready only while no search is running; the result sits in an output
// register, so the next request may be taken while a result still waits. Reset empties the
// table at once (entry count to zero); no clearing pass.
module key_occurrence_counter_core #(
    parameter int unsigned DEPTH     = koc_pkg::DEPTH_DEF,
    parameter int unsigned KEY_BYTES = koc_pkg::KEY_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    koc_key_if.sink   i_key,
    koc_res_if.source o_res
);

    localparam int unsigned KEY_W   = 8 * KEY_BYTES;
    localparam int unsigned COUNT_W = koc_pkg::COUNT_W;
    localparam int unsigned RAM_W   = KEY_W + COUNT_W;
    localparam int unsigned IW      = $clog2(DEPTH);
    localparam int unsigned CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] USED_FULL = CW'(DEPTH);

    koc_pkg::t_state r_state;
    koc_pkg::t_state n_state;

    // Search context
    logic [KEY_W-1:0]   r_key;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      r_rd_idx;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;

    // Result register
    logic               r_out_vld;
    logic [COUNT_W-1:0] r_count;
    logic               r_is_new;
    logic               r_full;

    // RAM port signals
    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    logic [RAM_W-1:0]   ram_wr_data;
    logic               ram_rd_en;
    logic [RAM_W-1:0]   ram_rd_data;

    logic [KEY_W-1:0]   rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic [COUNT_W-1:0] cnt_next;

    logic accept;
    logic hit;
    logic scan_done;
    logic decide;
    logic out_free;
    logic commit;
    logic tbl_full;

    assign rd_key = ram_rd_data[RAM_W-1:COUNT_W];
    assign rd_cnt = ram_rd_data[COUNT_W-1:0];

    // Shared compare / increment unit: one stored entry per cycle
    assign cnt_next  = (rd_cnt == koc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + koc_pkg::COUNT_ONE;
    assign hit       = (r_state == koc_pkg::S_SCAN) && r_cmp_vld && (rd_key == r_key);
    assign scan_done = (r_state == koc_pkg::S_SCAN) && !r_cmp_vld && (r_rd_idx == r_used);
    assign decide    = hit || scan_done;
    // The result register is free if empty or being emptied this cycle
    assign out_free  = !r_out_vld || o_res.ready;
    assign commit    = decide && out_free;
    assign tbl_full  = (r_used == USED_FULL);
    assign accept    = i_key.valid && i_key.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            koc_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = koc_pkg::S_SCAN;
                end
            end
            koc_pkg::S_SCAN: begin
                if (commit) begin
                    n_state = koc_pkg::S_IDLE;
                end
            end
            default: n_state = koc_pkg::S_IDLE;
        endcase
    end

    // State outputs: handshake, RAM read issue and write-back
    always_comb begin
        i_key.ready = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cmp_idx;
        ram_wr_data = {r_key, cnt_next};
        unique case (r_state)
            koc_pkg::S_IDLE: begin
                i_key.ready = 1'b1;
            end
            koc_pkg::S_SCAN: begin
                // Issue the next read unless the search ends this cycle or every entry in use has been read
                ram_rd_en = !decide && (r_rd_idx != r_used);
                if (commit) begin
                    if (hit) begin
                        ram_wr_en = 1'b1;
                    end else if (!tbl_full) begin
                        // Append at the first free entry
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_used[IW-1:0];
                        ram_wr_data = {r_key, koc_pkg::COUNT_ONE};
                    end
                end
            end
            default: begin
                i_key.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= koc_pkg::S_IDLE;
            r_used    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (ram_rd_en) begin
                // Advance the read pointer; data for this index arrives next cycle
                r_rd_idx  <= r_rd_idx + CW'(1);
                r_cmp_vld <= 1'b1;
            end else if (!(decide && !out_free)) begin
                // Drop the compare slot unless stalled on a full result register
                r_cmp_vld <= 1'b0;
            end
            if (commit && !hit && !tbl_full) begin
                r_used <= r_used + CW'(1);
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key.key[KEY_W-1:0];
        end
        if (ram_rd_en) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (commit) begin
            if (hit) begin
                r_count  <= cnt_next;
                r_is_new <= 1'b0;
                r_full   <= 1'b0;
            end else if (!tbl_full) begin
                r_count  <= koc_pkg::COUNT_ONE;
                r_is_new <= 1'b1;
                r_full   <= 1'b0;
            end else begin
                r_count  <= '0;
                r_is_new <= 1'b0;
                r_full   <= 1'b1;
            end
        end
    end

    koc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_koc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_idx[IW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    assign o_res.valid      = r_out_vld;
    assign o_res.count      = r_count;
    assign o_res.is_new     = r_is_new;
    assign o_res.table_full = r_full;

endmodule

/* design/koc_checker.sv */
// Port-level checks for the key occurrence counter, bound to the top level.
module koc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_key_valid,
    input logic                            i_key_ready,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [koc_pkg::COUNT_W-1:0]     i_res_count,
    input logic                            i_res_is_new,
    input logic                            i_res_table_full
);

    // A full-table result carries no count and no insertion
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_table_full) |-> (i_res_count == '0) && !i_res_is_new)
        else $error("table_full result with non-zero count or is_new");

    // An insertion always reports a count of one
    a_new_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_is_new) |-> (i_res_count == koc_pkg::COUNT_ONE))
        else $error("is_new result with count other than one");

    // A taken request blocks further requests for at least the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key_valid && i_key_ready) |=> !i_key_ready)
        else $error("request side ready straight after a request was taken");

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid && $stable(i_res_count)
            && $stable(i_res_is_new) && $stable(i_res_table_full))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid straight after reset");

endmodule

bind key_occurrence_counter_core koc_checker u_koc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_key_valid      (i_key.valid),
    .i_key_ready      (i_key.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_count      (o_res.count),
    .i_res_is_new     (o_res.is_new),
    .i_res_table_full (o_res.table_full)
);
